FILE: rtl/efm_pkg.sv
// Shared constants, types and codes for the emitter fingerprint matcher.
// Used by efm_cell, efm_sorter and emitter_fingerprint_matcher.
package efm_pkg;

    localparam int SLOTS   = 64;
    localparam int WINDOW  = 8;
    localparam int LANES   = 4;
    localparam int FEAT_W  = 16;
    localparam int MAC_W   = 48;
    localparam int FP_W    = 16;
    localparam int TOL_W   = 16;
    localparam int IDX_W   = 6;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int POS_W   = $clog2(WINDOW);
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int DRAIN_W = $clog2(WINDOW + 2);
    localparam int DIFF_W  = FEAT_W + 1;
    localparam int DIST_W  = DIFF_W + 2;
    localparam int CFG_W   = 2;

    localparam logic [1:0] ST_RECORDED = 2'd0;
    localparam logic [1:0] ST_GATED    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [CFG_W-1:0] REG_IRR_TOL = 2'd0;
    localparam logic [CFG_W-1:0] REG_DC_TOL  = 2'd1;
    localparam logic [CFG_W-1:0] REG_EPS_TOL = 2'd2;
    localparam logic [CFG_W-1:0] REG_PHI_TOL = 2'd3;

    localparam logic [TOL_W-1:0] IRR_TOL_RESET = 16'd768;
    localparam logic [TOL_W-1:0] DC_TOL_RESET  = 16'd768;
    localparam logic [TOL_W-1:0] EPS_TOL_RESET = 16'd512;
    localparam logic [TOL_W-1:0] PHI_TOL_RESET = 16'd512;

    typedef logic [LANES-1:0][FEAT_W-1:0] lanes_t;

    typedef struct packed {
        logic   valid;
        lanes_t data;
    } cell_link_t;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [FP_W-1:0]   fp;
        logic [POS_W-1:0]  head;
        logic [FILL_W-1:0] fill;
    } meta_t;

endpackage

FILE: rtl/emitter_fingerprint_matcher.sv
// Emitter fingerprint matcher: top level with scan sequencer and tables.
// A gated beat goes straight to the result; otherwise slots of the beat's kind are checked
// in order, a MAC entry by address and a fingerprint entry by the median of its window,
// before a match, a new entry or a full table is reported. One reading at a time: the next
// beat is taken the cycle after the result is loaded. Async active-low reset empties the
// table and restores tolerances.
module emitter_fingerprint_matcher (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [111:0]              s_axis_tdata,  // mac_address, irr, dc, eps, phi
    input  logic [1:0]                s_axis_tuser,  // gated, has_mac
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [23:0]               m_axis_tdata,  // entry_index, entry_new,
                                                     // entry_by_mac, fingerprint_number
    output logic [1:0]                m_axis_tuser,  // status
    input  logic                      cfg_we,
    input  logic [efm_pkg::CFG_W-1:0] cfg_addr,
    input  logic [efm_pkg::TOL_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_SCAN, S_META, S_WIN, S_DRAIN, S_MED, S_CMP,
        S_DECIDE, S_RDB, S_RDB_WAIT, S_OUT
    } state_t;

    state_t                          state_reg;
    logic [efm_pkg::TOL_W-1:0]       tol_reg [efm_pkg::LANES];
    logic [efm_pkg::SLOTS-1:0]       valid_reg;
    logic [efm_pkg::SLOTS-1:0]       is_mac_reg;
    logic [efm_pkg::SLOT_W:0]        used_reg;
    logic [efm_pkg::FP_W-1:0]        next_fp_reg;
    logic                            gated_reg;
    logic                            has_mac_reg;
    logic [efm_pkg::MAC_W-1:0]       mac_reg;
    efm_pkg::lanes_t                 feat_reg;
    logic [efm_pkg::SLOT_W:0]        slot_reg;
    logic [efm_pkg::POS_W-1:0]       pos_reg;
    logic [efm_pkg::FILL_W-1:0]      fill_reg;
    logic [efm_pkg::DRAIN_W-1:0]     drain_reg;
    efm_pkg::lanes_t                 med_reg;
    logic                            found_reg;
    logic [efm_pkg::SLOT_W-1:0]      best_reg;
    logic [efm_pkg::DIST_W-1:0]      best_score_reg;
    logic [1:0]                      res_status_reg;
    logic                            res_new_reg;
    logic                            res_by_mac_reg;
    logic [efm_pkg::FP_W-1:0]        res_fp_reg;
    logic                            out_valid_reg;
    logic [23:0]                     out_data_reg;
    logic [1:0]                      out_user_reg;

    efm_pkg::meta_t                  meta_mem [efm_pkg::SLOTS];
    efm_pkg::meta_t                  meta_q;
    logic [efm_pkg::SLOT_W-1:0]      meta_raddr;
    logic                            meta_we;
    logic [efm_pkg::SLOT_W-1:0]      meta_waddr;
    efm_pkg::meta_t                  meta_wdata;

    efm_pkg::lanes_t                 win_mem [efm_pkg::SLOTS*efm_pkg::WINDOW];
    efm_pkg::lanes_t                 win_q;
    logic                            win_rv_reg;
    logic                            win_we;
    logic [efm_pkg::SLOT_W+efm_pkg::POS_W-1:0] win_waddr;

    efm_pkg::cell_link_t             sort_in;
    efm_pkg::lanes_t                 sort_vals [efm_pkg::WINDOW];

    logic [efm_pkg::SLOT_W-1:0]      slot_idx;
    logic                            alloc;
    logic [efm_pkg::POS_W-1:0]       head_inc;
    logic [efm_pkg::FILL_W-1:0]      fill_inc;
    logic [efm_pkg::FILL_W-1:0]      half;
    efm_pkg::lanes_t                 med_calc;
    logic [efm_pkg::DIFF_W-1:0]      diff [efm_pkg::LANES];
    logic                            cand_ok;
    logic [efm_pkg::DIST_W-1:0]      cand_dist;

    assign slot_idx = slot_reg[efm_pkg::SLOT_W-1:0];
    assign alloc    = (state_reg == S_DECIDE) && !found_reg
                      && (used_reg != (efm_pkg::SLOT_W+1)'(efm_pkg::SLOTS));

    assign head_inc = (meta_q.head == efm_pkg::POS_W'(efm_pkg::WINDOW - 1))
                      ? '0 : meta_q.head + 1'b1;
    assign fill_inc = (meta_q.fill < efm_pkg::FILL_W'(efm_pkg::WINDOW))
                      ? meta_q.fill + 1'b1 : meta_q.fill;

    always_comb
    begin
        meta_raddr = (state_reg == S_RDB) ? best_reg : slot_idx;
        meta_we    = alloc || (state_reg == S_RDB_WAIT);
        win_we     = meta_we;
        if (alloc)
        begin
            meta_waddr      = used_reg[efm_pkg::SLOT_W-1:0];
            meta_wdata.mac  = has_mac_reg ? mac_reg : '0;
            meta_wdata.fp   = has_mac_reg ? '0 : next_fp_reg;
            meta_wdata.head = efm_pkg::POS_W'(1 % efm_pkg::WINDOW);
            meta_wdata.fill = efm_pkg::FILL_W'(1);
            win_waddr       = {used_reg[efm_pkg::SLOT_W-1:0], efm_pkg::POS_W'(0)};
        end
        else
        begin
            meta_waddr      = best_reg;
            meta_wdata.mac  = meta_q.mac;
            meta_wdata.fp   = meta_q.fp;
            meta_wdata.head = head_inc;
            meta_wdata.fill = fill_inc;
            win_waddr       = {best_reg, meta_q.head};
        end
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        meta_q <= meta_mem[meta_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[win_waddr] <= feat_reg;
        end
        win_q <= win_mem[{slot_idx, pos_reg}];
    end

    assign sort_in.valid = win_rv_reg;
    assign sort_in.data  = win_q;

    efm_sorter u_sorter (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (state_reg == S_META),
        .link_in (sort_in),
        .vals    (sort_vals)
    );

    assign half = fill_reg >> 1;

    always_comb
    begin
        logic signed [efm_pkg::FEAT_W:0] sum;
        logic [efm_pkg::POS_W-1:0]       hi_idx;
        logic [efm_pkg::POS_W-1:0]       lo_idx;
        hi_idx = half[efm_pkg::POS_W-1:0];
        lo_idx = hi_idx - 1'b1;
        for (int l = 0; l < efm_pkg::LANES; l++)
        begin
            sum = $signed({sort_vals[lo_idx][l][efm_pkg::FEAT_W-1], sort_vals[lo_idx][l]})
                + $signed({sort_vals[hi_idx][l][efm_pkg::FEAT_W-1], sort_vals[hi_idx][l]});
            if (fill_reg[0])
            begin
                med_calc[l] = sort_vals[hi_idx][l];
            end
            else
            begin
                med_calc[l] = efm_pkg::FEAT_W'(sum >>> 1);
            end
        end
    end

    always_comb
    begin
        logic signed [efm_pkg::DIFF_W-1:0] d;
        cand_ok   = 1'b1;
        cand_dist = '0;
        for (int l = 0; l < efm_pkg::LANES; l++)
        begin
            d = $signed({feat_reg[l][efm_pkg::FEAT_W-1], feat_reg[l]})
              - $signed({med_reg[l][efm_pkg::FEAT_W-1], med_reg[l]});
            diff[l] = d[efm_pkg::DIFF_W-1] ? efm_pkg::DIFF_W'(-d) : efm_pkg::DIFF_W'(d);
            if (diff[l] > {1'b0, tol_reg[l]})
            begin
                cand_ok = 1'b0;
            end
            cand_dist = cand_dist + efm_pkg::DIST_W'(diff[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tol_reg[0]     <= efm_pkg::IRR_TOL_RESET;
            tol_reg[1]     <= efm_pkg::DC_TOL_RESET;
            tol_reg[2]     <= efm_pkg::EPS_TOL_RESET;
            tol_reg[3]     <= efm_pkg::PHI_TOL_RESET;
            valid_reg      <= '0;
            is_mac_reg     <= '0;
            used_reg       <= '0;
            next_fp_reg    <= '0;
            win_rv_reg     <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    efm_pkg::REG_IRR_TOL: tol_reg[0] <= cfg_data;
                    efm_pkg::REG_DC_TOL:  tol_reg[1] <= cfg_data;
                    efm_pkg::REG_EPS_TOL: tol_reg[2] <= cfg_data;
                    efm_pkg::REG_PHI_TOL: tol_reg[3] <= cfg_data;
                    default: ;
                endcase
            end

            if (out_valid_reg && m_axis_tready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            win_rv_reg <= (state_reg == S_WIN);

            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        gated_reg   <= s_axis_tuser[0];
                        has_mac_reg <= s_axis_tuser[1];
                        mac_reg     <= s_axis_tdata[47:0];
                        feat_reg    <= s_axis_tdata[111:48];
                        state_reg   <= S_START;
                    end
                end
                S_START:
                begin
                    res_status_reg <= efm_pkg::ST_RECORDED;
                    res_new_reg    <= 1'b0;
                    res_by_mac_reg <= 1'b0;
                    res_fp_reg     <= '0;
                    best_reg       <= '0;
                    found_reg      <= 1'b0;
                    slot_reg       <= '0;
                    if (gated_reg)
                    begin
                        res_status_reg <= efm_pkg::ST_GATED;
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (slot_reg == (efm_pkg::SLOT_W+1)'(efm_pkg::SLOTS))
                    begin
                        state_reg <= S_DECIDE;
                    end
                    else if (valid_reg[slot_idx] && (is_mac_reg[slot_idx] == has_mac_reg))
                    begin
                        state_reg <= S_META;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                end
                S_META:
                begin
                    fill_reg <= meta_q.fill;
                    pos_reg  <= '0;
                    if (has_mac_reg)
                    begin
                        if (meta_q.mac == mac_reg)
                        begin
                            best_reg  <= slot_idx;
                            found_reg <= 1'b1;
                            state_reg <= S_DECIDE;
                        end
                        else
                        begin
                            slot_reg  <= slot_reg + 1'b1;
                            state_reg <= S_SCAN;
                        end
                    end
                    else if (meta_q.fill == '0)
                    begin
                        slot_reg  <= slot_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_WIN;
                    end
                end
                S_WIN:
                begin
                    pos_reg <= pos_reg + 1'b1;
                    if (efm_pkg::FILL_W'(pos_reg) == fill_reg - 1'b1)
                    begin
                        drain_reg <= efm_pkg::DRAIN_W'(efm_pkg::WINDOW + 1);
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    drain_reg <= drain_reg - 1'b1;
                    if (drain_reg == '0)
                    begin
                        state_reg <= S_MED;
                    end
                end
                S_MED:
                begin
                    med_reg   <= med_calc;
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (cand_ok && (!found_reg || cand_dist < best_score_reg))
                    begin
                        found_reg      <= 1'b1;
                        best_reg       <= slot_idx;
                        best_score_reg <= cand_dist;
                    end
                    slot_reg  <= slot_reg + 1'b1;
                    state_reg <= S_SCAN;
                end
                S_DECIDE:
                begin
                    if (found_reg)
                    begin
                        state_reg <= S_RDB;
                    end
                    else if (alloc)
                    begin
                        best_reg                <= used_reg[efm_pkg::SLOT_W-1:0];
                        used_reg                <= used_reg + 1'b1;
                        valid_reg[used_reg[efm_pkg::SLOT_W-1:0]]  <= 1'b1;
                        is_mac_reg[used_reg[efm_pkg::SLOT_W-1:0]] <= has_mac_reg;
                        res_new_reg             <= 1'b1;
                        res_by_mac_reg          <= has_mac_reg;
                        res_fp_reg              <= has_mac_reg ? '0 : next_fp_reg;
                        if (!has_mac_reg)
                        begin
                            next_fp_reg <= next_fp_reg + 1'b1;
                        end
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        res_status_reg <= efm_pkg::ST_FULL;
                        best_reg       <= '0;
                        state_reg      <= S_OUT;
                    end
                end
                S_RDB:
                begin
                    state_reg <= S_RDB_WAIT;
                end
                S_RDB_WAIT:
                begin
                    res_by_mac_reg <= has_mac_reg;
                    res_fp_reg     <= has_mac_reg ? '0 : meta_q.fp;
                    state_reg      <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_user_reg  <= res_status_reg;
                        out_data_reg  <= {res_fp_reg, res_by_mac_reg, res_new_reg,
                                          efm_pkg::IDX_W'(best_reg)};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

FILE: rtl/efm_cell.sv
// One sorting cell: keeps the smaller value per lane, passes the larger on.
// Depends on efm_pkg.
module efm_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  efm_pkg::cell_link_t link_in,
    output efm_pkg::cell_link_t link_out,
    output efm_pkg::lanes_t     held
);

    logic            occ_reg;
    logic            pass_valid_reg;
    efm_pkg::lanes_t held_reg;
    efm_pkg::lanes_t pass_reg;
    efm_pkg::lanes_t lo;
    efm_pkg::lanes_t hi;

    always_comb
    begin
        for (int l = 0; l < efm_pkg::LANES; l++)
        begin
            if ($signed(link_in.data[l]) < $signed(held_reg[l]))
            begin
                lo[l] = link_in.data[l];
                hi[l] = held_reg[l];
            end
            else
            begin
                lo[l] = held_reg[l];
                hi[l] = link_in.data[l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg        <= 1'b0;
            pass_valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            occ_reg        <= 1'b0;
            pass_valid_reg <= 1'b0;
        end
        else if (link_in.valid)
        begin
            occ_reg        <= 1'b1;
            pass_valid_reg <= occ_reg;
        end
        else
        begin
            pass_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_in.valid && !clear)
        begin
            if (!occ_reg)
            begin
                held_reg <= link_in.data;
            end
            else
            begin
                held_reg <= lo;
                pass_reg <= hi;
            end
        end
    end

    assign link_out.valid = pass_valid_reg;
    assign link_out.data  = pass_reg;
    assign held           = held_reg;

endmodule

FILE: rtl/efm_sorter.sv
// Row of sorting cells; after a run of beats, cell k holds the k-th smallest.
// Depends on efm_pkg and efm_cell.
module efm_sorter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  efm_pkg::cell_link_t link_in,
    output efm_pkg::lanes_t     vals [efm_pkg::WINDOW]
);

    efm_pkg::cell_link_t chain [efm_pkg::WINDOW+1];

    assign chain[0] = link_in;

    for (genvar k = 0; k < efm_pkg::WINDOW; k++)
    begin : g_cell
        efm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clear    (clear),
            .link_in  (chain[k]),
            .link_out (chain[k+1]),
            .held     (vals[k])
        );
    end

endmodule
